FILE: rtl/core/tfae_pkg.sv
// Shared constants, codes and types of the timestamp FIFO with age expiry.
package tfae_pkg;

  localparam int unsigned FIFO_DEPTH = 1024;
  localparam int unsigned STAMP_W    = 64;
  localparam int unsigned AMT_W      = 32;
  localparam int unsigned OP_W       = 2;
  localparam int unsigned CNT_W      = 11;
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 16;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT  = 2'd0,
    OP_ADVANCE = 2'd1,
    OP_EXPIRE  = 2'd2,
    OP_NONE    = 2'd3
  } opcode_t;

  typedef enum logic {
    ST_IDLE   = 1'b0,
    ST_EXPIRE = 1'b1
  } state_t;

  // Broadcast to every cell in the chain.
  typedef struct packed {
    logic               pop;
    logic               ins;
    logic [STAMP_W-1:0] stamp;
  } cell_ctrl_t;

endpackage

FILE: rtl/core/tfae_cell.sv
// One storage cell of the stamp chain: holds a stamp and its valid bit.
module tfae_cell
  import tfae_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  cell_ctrl_t         ctrl,
  input  logic               prev_valid,
  input  logic               next_valid,
  input  logic [STAMP_W-1:0] next_stamp,
  output logic               valid,
  output logic [STAMP_W-1:0] stamp
);

  logic               valid_r, valid_nxt;
  logic [STAMP_W-1:0] stamp_r, stamp_nxt;

  always_comb begin
    valid_nxt = valid_r;
    stamp_nxt = stamp_r;
    if (ctrl.pop) begin
      // take the neighbor's entry, chain moves toward the head
      valid_nxt = next_valid;
      stamp_nxt = next_stamp;
    end else if (ctrl.ins && !valid_r && prev_valid) begin
      // first free cell captures the new stamp
      valid_nxt = 1'b1;
      stamp_nxt = ctrl.stamp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    stamp_r <= stamp_nxt;
  end

  assign valid = valid_r;
  assign stamp = stamp_r;

endmodule

FILE: rtl/core/timestamp_fifo_age_expiry.sv
// Top level: timestamp FIFO built as a chain of cells, with clock and age expiry.
//
//   channel | dir | handshake             | payload
//   --------+-----+-----------------------+--------------------------------------
//   in      | in  | in_tvalid/in_tready   | in_tdata: opcode[1:0], amount[33:2]
//   out     | out | out_tvalid/out_tready | out_tdata: expired_count[10:0]
//
// Insert, advance and unused opcodes act in the cycle that accepts them. An
// expire removes head entries one at a time while the head cell's age compare
// finds the head old, shifting the chain one step per removal, and finishes
// once the head entry is young or the chain is empty. The result lands in an
// output register, so new items are accepted while it waits; a finishing
// expire holds until the register is free. Synchronous active-low reset
// empties the chain and clears the clock.
module timestamp_fifo_age_expiry
  import tfae_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // opcode[1:0], amount[33:2], zero pad
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata   // expired_count[10:0], zero pad
);

  state_t             state_r, state_nxt;
  logic [STAMP_W-1:0] clock_r, clock_nxt;
  logic [AMT_W-1:0]   thr_r, thr_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [CNT_W-1:0]   out_cnt_r, out_cnt_nxt;

  opcode_t            in_op;
  logic [AMT_W-1:0]   in_amount;
  logic               in_fire;
  logic               out_free;
  logic [STAMP_W-1:0] head_age;
  logic               head_old;
  cell_ctrl_t         ctrl;

  logic               valid_w [FIFO_DEPTH];
  logic [STAMP_W-1:0] stamp_w [FIFO_DEPTH];

  // Unpack the input item.
  assign in_op     = opcode_t'(in_tdata[OP_W-1:0]);
  assign in_amount = in_tdata[OP_W+AMT_W-1:OP_W];
  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  // Age of the head entry, wrapping like the clock.
  assign head_age = clock_r - stamp_w[0];
  assign head_old = valid_w[0] && (head_age >= {{(STAMP_W-AMT_W){1'b0}}, thr_r});

  always_comb begin
    state_nxt     = state_r;
    clock_nxt     = clock_r;
    thr_nxt       = thr_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    out_cnt_nxt   = out_cnt_r;
    ctrl.pop      = 1'b0;
    ctrl.ins      = 1'b0;
    ctrl.stamp    = clock_r;

    // Release the result register once taken.
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (in_op)
            OP_INSERT: begin
              // the chain drops the insert by itself when the last cell is full
              ctrl.ins = 1'b1;
            end
            OP_ADVANCE: begin
              clock_nxt = clock_r + {{(STAMP_W-AMT_W){1'b0}}, in_amount};
            end
            OP_EXPIRE: begin
              thr_nxt   = in_amount;
              cnt_nxt   = '0;
              state_nxt = ST_EXPIRE;
            end
            OP_NONE: begin
            end
            default: begin
            end
          endcase
        end
      end
      ST_EXPIRE: begin
        if (head_old) begin
          // drop the head entry and shift the chain by one
          ctrl.pop = 1'b1;
          cnt_nxt  = cnt_r + CNT_W'(1);
        end else if (out_free) begin
          // head is young or chain empty: report and return to idle
          out_valid_nxt = 1'b1;
          out_cnt_nxt   = cnt_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      clock_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clock_r     <= clock_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    thr_r     <= thr_nxt;
    cnt_r     <= cnt_nxt;
    out_cnt_r <= out_cnt_nxt;
  end

  // Chain of cells, head at index zero.
  for (genvar i = 0; i < FIFO_DEPTH; i++) begin : g_cell
    logic               prev_v;
    logic               next_v;
    logic [STAMP_W-1:0] next_s;

    if (i == 0) begin : g_first
      assign prev_v = 1'b1;
    end else begin : g_inner_prev
      assign prev_v = valid_w[i-1];
    end

    if (i == FIFO_DEPTH-1) begin : g_last
      assign next_v = 1'b0;
      assign next_s = '0;
    end else begin : g_inner_next
      assign next_v = valid_w[i+1];
      assign next_s = stamp_w[i+1];
    end

    tfae_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .prev_valid (prev_v),
      .next_valid (next_v),
      .next_stamp (next_s),
      .valid      (valid_w[i]),
      .stamp      (stamp_w[i])
    );
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W-CNT_W){1'b0}}, out_cnt_r};

endmodule
